### rtl/rfl_pkg.sv
// ----------------------------------------------------------------------------
// Reflection package
// Shared widths, constants and types of the normalized axis reflection block.
// ----------------------------------------------------------------------------
package rfl_pkg;

    localparam int NORM_BITS = 30;
    localparam int OUT_W     = 16;
    localparam int FRAC_OUT  = 14;
    localparam int OUT_ONE   = 16384;
    localparam int SUM_W     = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int NUM_W     = NORM_BITS + FRAC_OUT + 1;
    localparam int QUO_W     = FRAC_OUT + 1;

    typedef logic [NORM_BITS-1:0]        t_norm;
    typedef logic [2:0][NORM_BITS-1:0]   t_norm3;
    typedef logic [SUM_W-1:0]            t_sum;
    typedef logic [ROOT_W-1:0]           t_root;
    typedef logic [2:0][NUM_W-1:0]       t_num3;
    typedef logic [2:0][QUO_W-1:0]       t_quo3;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_flags;

    typedef struct packed {
        t_norm3 c;
        t_flags flags;
    } t_side;

endpackage

### rtl/rfl_front.sv
// ----------------------------------------------------------------------------
// Reflection front end
// Forms r = 2(a.v)a - v exactly, scales it to 30 significant bits and sums
// the squares of the scaled components, in eight register stages.
// ----------------------------------------------------------------------------
module rfl_front #(
    parameter int CW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0][CW-1:0]  i_axis,
    input  logic [2:0][CW-1:0]  i_vec,
    output logic                o_valid,
    output rfl_pkg::t_sum       o_sum,
    output rfl_pkg::t_side      o_side
);
    import rfl_pkg::*;

    localparam int FB   = CW - 4;
    localparam int PW   = 2 * CW;
    localparam int DW   = 2 * CW + 2;
    localparam int TW   = DW + 1;
    localparam int MULW = TW + CW;
    localparam int RWID = MULW + 1;
    localparam int MAGW = RWID - 1;
    localparam int XW   = (MAGW > NORM_BITS) ? MAGW : NORM_BITS;
    localparam int LZW  = $clog2(XW);
    localparam int SQW  = 2 * NORM_BITS;

    logic                   r1_valid, r2_valid, r3_valid, r4_valid;
    logic                   r5_valid, r6_valid, r7_valid, r8_valid;
    logic signed [PW-1:0]   r1_prod [3];
    logic [2:0][CW-1:0]     r1_a, r1_v, r2_a, r2_v, r3_v;
    logic signed [TW-1:0]   r2_two;
    logic signed [MULW-1:0] r3_t [3];
    logic [MAGW-1:0]        r4_mag [3];
    logic [MAGW-1:0]        r5_mag [3];
    logic [2:0]             r4_neg, r5_neg, r6_neg, r7_neg, r8_neg;
    logic                   r5_zero, r6_zero, r7_zero, r8_zero;
    logic [LZW-1:0]         r5_lz;
    t_norm3                 r6_c, r7_c, r8_c;
    logic [SQW-1:0]         r7_sq [3];
    t_sum                   r8_sum;

    logic signed [DW-1:0]   n2_dot;
    logic signed [RWID-1:0] n4_r [3];
    logic [MAGW-1:0]        n5_or;
    logic [XW-1:0]          n5_ext;
    logic [LZW-1:0]         n5_lz;
    logic [XW-1:0]          n6_sh [3];

    always_comb begin
        n2_dot = DW'(r1_prod[0]) + DW'(r1_prod[1]) + DW'(r1_prod[2]);
        for (int i = 0; i < 3; i++) begin
            n4_r[i] = RWID'(r3_t[i]) - (RWID'($signed(r3_v[i])) <<< (2 * FB));
        end
        n5_or  = r4_mag[0] | r4_mag[1] | r4_mag[2];
        n5_ext = XW'(n5_or) << (XW - MAGW);
        n5_lz  = '0;
        for (int i = 0; i < XW; i++) begin
            if (n5_ext[i]) begin
                n5_lz = LZW'(XW - 1 - i);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n6_sh[i] = (XW'(r5_mag[i]) << (XW - MAGW)) << r5_lz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_prod[i] <= $signed(i_axis[i]) * $signed(i_vec[i]);
            r3_t[i]    <= r2_two * $signed(r2_a[i]);
            r4_neg[i]  <= n4_r[i][RWID-1];
            r4_mag[i]  <= n4_r[i][RWID-1] ? MAGW'(-n4_r[i]) : MAGW'(n4_r[i]);
            r5_mag[i]  <= r4_mag[i];
            r6_c[i]    <= n6_sh[i][XW-1 -: NORM_BITS];
            r7_sq[i]   <= r6_c[i] * r6_c[i];
        end
        r1_a    <= i_axis;
        r1_v    <= i_vec;
        r2_a    <= r1_a;
        r2_v    <= r1_v;
        r2_two  <= {n2_dot, 1'b0};
        r3_v    <= r2_v;
        r5_neg  <= r4_neg;
        r5_zero <= (n5_or == '0);
        r5_lz   <= n5_lz;
        r6_neg  <= r5_neg;
        r6_zero <= r5_zero;
        r7_neg  <= r6_neg;
        r7_zero <= r6_zero;
        r7_c    <= r6_c;
        r8_neg  <= r7_neg;
        r8_zero <= r7_zero;
        r8_c    <= r7_c;
        r8_sum  <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);
    end

    assign o_valid          = r8_valid;
    assign o_sum            = r8_sum;
    assign o_side.c         = r8_c;
    assign o_side.flags.neg = r8_neg;
    assign o_side.flags.zero = r8_zero;

endmodule

### rtl/rfl_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rfl_isqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rfl_pkg::t_sum  i_op,
    input  rfl_pkg::t_side i_side,
    output logic           o_valid,
    output rfl_pkg::t_root o_root,
    output rfl_pkg::t_side o_side
);
    import rfl_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0] r_rem   [ROOT_W];
    t_root            r_res   [ROOT_W];
    t_sum             r_op    [ROOT_W];
    t_side            r_side  [ROOT_W];
    logic             r_valid [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] w_rem_in, w_rem_sh, w_trial;
        t_root            w_res_in;
        t_sum             w_op_in;
        t_side            w_side_in;
        logic             w_valid_in, w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in   = '0;
            assign w_res_in   = '0;
            assign w_op_in    = i_op;
            assign w_side_in  = i_side;
            assign w_valid_in = i_valid;
        end else begin : g_next
            assign w_rem_in   = r_rem[k-1];
            assign w_res_in   = r_res[k-1];
            assign w_op_in    = r_op[k-1];
            assign w_side_in  = r_side[k-1];
            assign w_valid_in = r_valid[k-1];
        end

        assign w_rem_sh = {w_rem_in[REM_W-3:0], w_op_in[SUM_W-1 -: 2]};
        assign w_trial  = {w_res_in, 2'b01};
        assign w_ge     = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_res[k]  <= {w_res_in[ROOT_W-2:0], w_ge};
            r_op[k]   <= w_op_in << 2;
            r_side[k] <= w_side_in;
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

### rtl/rfl_div.sv
// ----------------------------------------------------------------------------
// Pipelined three lane divider
// Restoring division of three numerators by a shared divisor, one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
module rfl_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rfl_pkg::t_num3  i_num,
    input  rfl_pkg::t_root  i_den,
    input  rfl_pkg::t_flags i_flags,
    output logic            o_valid,
    output rfl_pkg::t_quo3  o_quo,
    output rfl_pkg::t_flags o_flags
);
    import rfl_pkg::*;

    t_num3  r_rem   [QUO_W];
    t_quo3  r_quo   [QUO_W];
    t_root  r_den   [QUO_W];
    t_flags r_flags [QUO_W];
    logic   r_valid [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        t_num3          w_rem_in;
        t_quo3          w_quo_in;
        t_root          w_den_in;
        t_flags         w_flags_in;
        logic           w_valid_in;
        logic [NUM_W:0] w_dsh;

        if (j == 0) begin : g_first
            assign w_rem_in   = i_num;
            assign w_quo_in   = '0;
            assign w_den_in   = i_den;
            assign w_flags_in = i_flags;
            assign w_valid_in = i_valid;
        end else begin : g_next
            assign w_rem_in   = r_rem[j-1];
            assign w_quo_in   = r_quo[j-1];
            assign w_den_in   = r_den[j-1];
            assign w_flags_in = r_flags[j-1];
            assign w_valid_in = r_valid[j-1];
        end

        assign w_dsh = (NUM_W + 1)'(w_den_in) << (QUO_W - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else begin
                r_valid[j] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, w_rem_in[i]} >= w_dsh) begin
                    r_rem[j][i] <= w_rem_in[i] - w_dsh[NUM_W-1:0];
                    r_quo[j][i] <= {w_quo_in[i][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[j][i] <= w_rem_in[i];
                    r_quo[j][i] <= {w_quo_in[i][QUO_W-2:0], 1'b0};
                end
            end
            r_den[j]   <= w_den_in;
            r_flags[j] <= w_flags_in;
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_flags = r_flags[QUO_W-1];

endmodule

### rtl/reflect_about_axis_normalized.sv
// ----------------------------------------------------------------------------
// Normalized reflection about an axis
// Computes r = 2(a.v)a - v and scales it to unit length in signed Q1.14.
// A zero reflected vector gives zero outputs and raises o_zero_length.
// ----------------------------------------------------------------------------
// Channel     Direction  Handshake                Payload
// command     in         start high, busy low     i_axis_*, i_vec_*
// result      out        o_strobe for one cycle   o_out_*, o_zero_length
//
// A transaction may be started in every cycle; busy is never raised.
// Each result passes through eight front end stages, one stage per square
// root bit, one numerator stage, one stage per quotient bit and the output
// register.
// Synchronous reset clears all valid bits; results in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module reflect_about_axis_normalized #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COMPONENT_WIDTH-1:0]  i_axis_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  i_axis_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  i_axis_z,
    input  logic signed [COMPONENT_WIDTH-1:0]  i_vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  i_vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  i_vec_z,
    output logic                               o_strobe,
    output logic signed [rfl_pkg::OUT_W-1:0]   o_out_x,
    output logic signed [rfl_pkg::OUT_W-1:0]   o_out_y,
    output logic signed [rfl_pkg::OUT_W-1:0]   o_out_z,
    output logic                               o_zero_length
);
    import rfl_pkg::*;

    logic                            w_front_valid, w_root_valid, w_div_valid;
    t_sum                            w_front_sum;
    t_side                           w_front_side, w_root_side;
    t_root                           w_root;
    t_quo3                           w_quo;
    t_flags                          w_div_flags;
    logic [2:0][COMPONENT_WIDTH-1:0] w_axis, w_vec;

    logic                            r_num_valid;
    t_num3                           r_num;
    t_root                           r_den;
    t_flags                          r_num_flags;
    logic                            r_strobe;
    logic [2:0][OUT_W-1:0]           r_out;
    logic                            r_zero;

    assign busy   = 1'b0;
    assign w_axis = {i_axis_z, i_axis_y, i_axis_x};
    assign w_vec  = {i_vec_z, i_vec_y, i_vec_x};

    rfl_front #(
        .CW (COMPONENT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_axis  (w_axis),
        .i_vec   (w_vec),
        .o_valid (w_front_valid),
        .o_sum   (w_front_sum),
        .o_side  (w_front_side)
    );

    rfl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .i_op    (w_front_sum),
        .i_side  (w_front_side),
        .o_valid (w_root_valid),
        .o_root  (w_root),
        .o_side  (w_root_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_valid <= 1'b0;
        end else begin
            r_num_valid <= w_root_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_num[i] <= (NUM_W'(w_root_side.c[i]) << FRAC_OUT) + NUM_W'(w_root >> 1);
        end
        r_den       <= w_root;
        r_num_flags <= w_root_side.flags;
    end

    rfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_num_valid),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_flags (r_num_flags),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_flags (w_div_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            logic [OUT_W-1:0] v_mag;
            v_mag = (w_quo[i] > QUO_W'(OUT_ONE)) ? OUT_W'(OUT_ONE) : OUT_W'(w_quo[i]);
            if (w_div_flags.zero) begin
                r_out[i] <= '0;
            end else if (w_div_flags.neg[i]) begin
                r_out[i] <= -v_mag;
            end else begin
                r_out[i] <= v_mag;
            end
        end
        r_zero <= w_div_flags.zero;
    end

    assign o_strobe      = r_strobe;
    assign o_out_x       = r_out[0];
    assign o_out_y       = r_out[1];
    assign o_out_z       = r_out[2];
    assign o_zero_length = r_zero;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_zero_length |-> o_out_x == 0 && o_out_y == 0 && o_out_z == 0)
        else $error("zero length result has nonzero components");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_out_x <= 16384 && o_out_x >= -16384 && o_out_y <= 16384
            && o_out_y >= -16384 && o_out_z <= 16384 && o_out_z >= -16384)
        else $error("result component exceeds unit magnitude");

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_valid && w_front_side.flags.zero |-> w_front_sum == '0)
        else $error("zero length vector has nonzero square sum");

    a_root_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num_valid && !r_num_flags.zero |-> r_den[ROOT_W-1:NORM_BITS-1] != '0)
        else $error("root of normalized vector below expected range");

endmodule
